// ===== rtl/tks_pkg.sv =====
package tks_pkg;

  localparam int SCORE_W = 16;
  localparam int ID_W    = 16;
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd15;

  // Operation codes of an input transaction.
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_PUSH  = 1'b1;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic exec;     // on a push update the cell row; always load the result register
  } dp_cmd_t;

endpackage

// ===== rtl/tks_ctrl.sv =====
module tks_ctrl import tks_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == ST_WORK) && out_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        // Holds here while the previous result has not been taken.
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/tks_datapath.sv =====
module tks_datapath import tks_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  input  cap_t    capacity,
  input  logic    in_operation,
  input  score_t  in_score,
  input  id_t     in_item_id,
  output logic    out_would_accept,
  output logic    out_added_valid,
  output id_t     out_added_id,
  output logic    out_evicted_valid,
  output id_t     out_evicted_id,
  output count_t  out_entry_count
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  // Captured transaction.
  logic   op_r;
  score_t score_r;
  id_t    id_r;

  // Cell row, slot 0 holds the lowest score.
  score_t cell_score_r [MAX_ENTRIES];
  id_t    cell_id_r    [MAX_ENTRIES];
  score_t cell_score_nxt [MAX_ENTRIES];
  id_t    cell_id_nxt    [MAX_ENTRIES];
  logic [CW-1:0] held_r, held_nxt;

  // Result register.
  logic   res_accept_r, res_added_r, res_evicted_r;
  id_t    res_added_id_r, res_evicted_id_r;
  count_t res_count_r;

  logic [EW-1:0] cap_ext, eff_cap, held_ext;
  logic          full, push, evict, accept;

  score_t              sc_ext [MAX_ENTRIES+1];
  id_t                 id_ext [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0] le_ext;

  assign push     = (op_r == OP_PUSH);
  assign cap_ext  = EW'(capacity);
  assign held_ext = EW'(held_r);

  // A capacity of zero acts as one; larger than the row saturates.
  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Full implies at least one entry, so slot 0 is valid here.
  assign full   = (held_ext >= eff_cap);
  assign evict  = push && full;
  assign accept = !full || (score_r > cell_score_r[0]);

  // Each cell flags whether it holds a valid score not above the new one.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sc_ext[i] = cell_score_r[i];
      id_ext[i] = cell_id_r[i];
      le_ext[i] = (CW'(i) < held_r) && (cell_score_r[i] <= score_r);
    end
    sc_ext[MAX_ENTRIES] = '0;
    id_ext[MAX_ENTRIES] = '0;
    le_ext[MAX_ENTRIES] = 1'b0;
  end

  // With an eviction every cell looks one slot higher, so the removal of
  // the lowest entry and the insertion happen in the same update. Cells
  // below the insertion point keep their source, the cell at it takes the
  // new entry and cells above take the entry from below.
  always_comb begin
    logic   src_le, below_le;
    score_t src_sc, prev_sc;
    id_t    src_id, prev_id;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      src_le  = evict ? le_ext[j+1] : le_ext[j];
      src_sc  = evict ? sc_ext[j+1] : sc_ext[j];
      src_id  = evict ? id_ext[j+1] : id_ext[j];
      if (j == 0) begin
        below_le = 1'b1;
        prev_sc  = sc_ext[0];
        prev_id  = id_ext[0];
      end else begin
        below_le = evict ? le_ext[j] : le_ext[j-1];
        prev_sc  = evict ? sc_ext[j] : sc_ext[j-1];
        prev_id  = evict ? id_ext[j] : id_ext[j-1];
      end
      if (src_le) begin
        cell_score_nxt[j] = src_sc;
        cell_id_nxt[j]    = src_id;
      end else if (below_le) begin
        cell_score_nxt[j] = score_r;
        cell_id_nxt[j]    = id_r;
      end else begin
        cell_score_nxt[j] = prev_sc;
        cell_id_nxt[j]    = prev_id;
      end
    end
  end

  assign held_nxt = (push && !evict) ? held_r + CW'(1) : held_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      score_r <= in_score;
      id_r    <= in_item_id;
    end
    if (cmd.exec && push) begin
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        cell_score_r[j] <= cell_score_nxt[j];
        cell_id_r[j]    <= cell_id_nxt[j];
      end
    end
    if (cmd.exec) begin
      res_accept_r     <= accept;
      res_added_r      <= push;
      res_added_id_r   <= push ? id_r : '0;
      res_evicted_r    <= evict;
      res_evicted_id_r <= evict ? cell_id_r[0] : '0;
      res_count_r      <= COUNT_W'(held_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.exec) begin
      held_r <= held_nxt;
    end
  end

  assign out_would_accept  = res_accept_r;
  assign out_added_valid   = res_added_r;
  assign out_added_id      = res_added_id_r;
  assign out_evicted_valid = res_evicted_r;
  assign out_evicted_id    = res_evicted_id_r;
  assign out_entry_count   = res_count_r;

endmodule

// ===== rtl/top_k_score_keeper_top.sv =====
// Keeps the highest-scoring (score, id) entries, up to the programmed capacity, in a row
// of compare-and-shift cells sorted by score. A query transaction reports whether its
// score would be kept; a push always inserts and, when the list is full, first drops
// the lowest (oldest among equal scores) entry and reports its id. Each transaction is
// first captured, and then, in the work state, every cell compares against the
// new score and shifts in parallel; a new transaction is taken while the previous result
// waits at the output, and the update stalls only if that result is still not taken.
// The capacity register (byte address 0) may be written only while the block is idle.
module top_k_score_keeper_top import tks_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  score_t      in_score,
  input  id_t         in_item_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_would_accept,
  output logic        out_added_valid,
  output id_t         out_added_id,
  output logic        out_evicted_valid,
  output id_t         out_evicted_id,
  output count_t      out_entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register index taken from the word address bit.
  localparam logic REG_CAPACITY = 1'b0;

  cap_t    capacity_r;
  dp_cmd_t cmd;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  tks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tks_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .capacity          (capacity_r),
    .in_operation      (in_operation),
    .in_score          (in_score),
    .in_item_id        (in_item_id),
    .out_would_accept  (out_would_accept),
    .out_added_valid   (out_added_valid),
    .out_added_id      (out_added_id),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_id    (out_evicted_id),
    .out_entry_count   (out_entry_count)
  );

  // A query result never reports an insertion or an eviction.
  a_query_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_added_valid |-> !out_evicted_valid && out_added_id == '0)
    else $error("query result reports a list change");

  // Only one transaction is in flight inside the block.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  // An update is never issued while an untaken result would be overwritten.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !out_valid || out_ready)
    else $error("result register overwritten before it was taken");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output valid or busy after reset");

endmodule
